@@ src/nsgs_pkg.sv @@
`timescale 1ns / 1ps

package nsgs_pkg;

  localparam int MAX_NODES  = 1024;
  localparam int MAX_DEGREE = 16;

  localparam int NODE_W = $clog2(MAX_NODES);
  localparam int CNT_W  = NODE_W + 1;
  localparam int SLOT_W = $clog2(MAX_DEGREE);
  localparam int DEG_W  = SLOT_W + 1;
  localparam int TAB_AW = NODE_W + SLOT_W;
  localparam int RATE_W = 29;
  localparam int TOT_W  = RATE_W + NODE_W;
  localparam int CFG_W  = 32;

  localparam logic [RATE_W-1:0] RATE_MAX = '1;
  localparam logic [31:0]       LN2_Q32  = 32'hB172_17F8;

  localparam int IN_W  = 120;
  localparam int OUT_W = 96;

  // output tdata layout
  localparam int O_CODE = 0;
  localparam int O_EV   = 3;
  localparam int O_TIME = 13;
  localparam int O_INFR = 45;
  localparam int O_SC   = 55;
  localparam int O_INF  = 60;
  localparam int O_SUS  = 71;
  localparam int O_REC  = 82;

  localparam logic [1:0] NS_SUS = 2'd0;
  localparam logic [1:0] NS_INF = 2'd1;
  localparam logic [1:0] NS_REC = 2'd2;

  typedef enum logic [1:0] {
    CMD_ADD  = 2'd0,
    CMD_SEED = 2'd1,
    CMD_SIM  = 2'd2
  } cmd_e;

  typedef enum logic [2:0] {
    STATUS_STORED    = 3'd0,
    STATUS_FULL      = 3'd1,
    STATUS_SEEDED    = 3'd2,
    STATUS_INFECTION = 3'd3,
    STATUS_RECOVERY  = 3'd4,
    STATUS_FINISHED  = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    REG_NODE_COUNT   = 2'd0,
    REG_INFECT_RATE  = 2'd1,
    REG_RECOVER_RATE = 2'd2,
    REG_MAX_TIME     = 2'd3
  } cfg_reg_e;

  typedef enum logic [4:0] {
    FSM_CLEAR, FSM_IDLE, FSM_SCAN, FSM_DECIDE, FSM_ADD_RD, FSM_SEED_RD,
    FSM_TGT_LO, FSM_TGT_HI, FSM_TGT_SUM, FSM_PICK, FSM_EV_RD, FSM_EV_ST,
    FSM_INFECT, FSM_RECOVER, FSM_DEG, FSM_NB_ADDR, FSM_NB_TAB, FSM_NB_ST,
    FSM_NB_RATE, FSM_WANT_MUL, FSM_WANT, FSM_LOG, FSM_NORM, FSM_SQ_MUL,
    FSM_SQ, FSM_LN_HI, FSM_LN_LO, FSM_LN_SUM, FSM_DIV, FSM_TIME, FSM_FINISH
  } fsm_e;

endpackage

@@ src/nsgs_ram.sv @@
`timescale 1ns / 1ps

module nsgs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ src/network_sir_gillespie_step_core.sv @@
`timescale 1ns / 1ps

// Gillespie SIR step engine on a stored contact graph. Each input transfer is one
// command (add neighbor entry, seed infection, simulate one event) and gives exactly
// one result transfer. After reset the node memories are swept to zero, during which
// no input is taken. Every command first scans the active nodes once for the tallies
// and the total rate through the node memories' single read port. An add then reads
// the degree and stores the entry if there is room; a seed walks the neighbor entries.
// A simulate step scans the rates a second time to pick the event node, walks the
// neighbor list up to twice, and then runs -ln(u) through one shared 32x32 multiplier
// (normalize and squaring steps) and a bit-serial divider. The block takes one item
// at a time.

module network_sir_gillespie_step_core
  import nsgs_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  // command, node, neighbor, pick_fraction, time_fraction, infector_fraction
  input  logic [IN_W-1:0]   s_axis_tdata,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  // status_code, event_node, event_time, infector_node, susceptible_contacts,
  // infected_count, susceptible_count, recovered_count
  output logic [OUT_W-1:0]  m_axis_tdata,
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_addr_i,
  input  logic [CFG_W-1:0]  cfg_wdata_i
);

  // configuration
  logic [CNT_W-1:0] ncount_q;
  logic [23:0]      beta_q, gamma_q;
  logic [31:0]      tmax_q;
  logic [CNT_W-1:0] n_eff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ncount_q <= CNT_W'(MAX_NODES);
      beta_q   <= 24'd65536;
      gamma_q  <= 24'd65536;
      tmax_q   <= '1;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_addr_i))
        REG_NODE_COUNT:   ncount_q <= cfg_wdata_i[CNT_W-1:0];
        REG_INFECT_RATE:  beta_q   <= cfg_wdata_i[23:0];
        REG_RECOVER_RATE: gamma_q  <= cfg_wdata_i[23:0];
        REG_MAX_TIME:     tmax_q   <= cfg_wdata_i[31:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (ncount_q == '0) n_eff = CNT_W'(1);
    else if (ncount_q > CNT_W'(MAX_NODES)) n_eff = CNT_W'(MAX_NODES);
    else n_eff = ncount_q;
  end

  // memories
  logic              st_we, rt_we, dg_we, tb_we;
  logic [NODE_W-1:0] st_waddr, st_raddr, rt_waddr, rt_raddr, dg_waddr, dg_raddr;
  logic [1:0]        st_wdata, st_rdata;
  logic [RATE_W-1:0] rt_wdata, rt_rdata;
  logic [DEG_W-1:0]  dg_wdata, dg_rdata;
  logic [TAB_AW-1:0] tb_waddr, tb_raddr;
  logic [NODE_W-1:0] tb_wdata, tb_rdata;

  nsgs_ram #(.WIDTH(2), .DEPTH(MAX_NODES)) u_state_ram (
    .clk_i, .we_i(st_we), .waddr_i(st_waddr), .wdata_i(st_wdata),
    .raddr_i(st_raddr), .rdata_o(st_rdata)
  );
  nsgs_ram #(.WIDTH(RATE_W), .DEPTH(MAX_NODES)) u_rate_ram (
    .clk_i, .we_i(rt_we), .waddr_i(rt_waddr), .wdata_i(rt_wdata),
    .raddr_i(rt_raddr), .rdata_o(rt_rdata)
  );
  nsgs_ram #(.WIDTH(DEG_W), .DEPTH(MAX_NODES)) u_degree_ram (
    .clk_i, .we_i(dg_we), .waddr_i(dg_waddr), .wdata_i(dg_wdata),
    .raddr_i(dg_raddr), .rdata_o(dg_rdata)
  );
  nsgs_ram #(.WIDTH(NODE_W), .DEPTH(MAX_NODES * MAX_DEGREE)) u_table_ram (
    .clk_i, .we_i(tb_we), .waddr_i(tb_waddr), .wdata_i(tb_wdata),
    .raddr_i(tb_raddr), .rdata_o(tb_rdata)
  );

  // registers
  fsm_e              state_q, state_d;
  logic [NODE_W-1:0] clr_q, clr_d;
  logic [1:0]        cmd_q, cmd_d;
  logic [NODE_W-1:0] node_q, node_d, nb_q, nb_d;
  logic [31:0]       pf_q, pf_d, tf_q, tf_d, ff_q, ff_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              rvld_q, rvld_d;
  logic [NODE_W-1:0] ridx_q, ridx_d;
  logic [CNT_W-1:0]  sus_q, sus_d, inf_q, inf_d, rec_q, rec_d;
  logic [TOT_W-1:0]  tot_q, tot_d;
  logic [TOT_W:0]    tgt_q, tgt_d, cum_q, cum_d;
  logic              found_q, found_d;
  logic [NODE_W-1:0] ev_q, ev_d, infr_q, infr_d, v_q, v_d;
  status_e           code_q, code_d;
  logic [DEG_W-1:0]  sc_q, sc_d, deg_q, deg_d, j_q, j_d, k_q, k_d, seen_q, seen_d;
  logic              seed_q, seed_d, recov_q, recov_d, pass2_q, pass2_d;
  logic [SLOT_W-1:0] want_q, want_d;
  logic [31:0]       x_q, x_d, frac_q, frac_d;
  logic [4:0]        e_q, e_d, b_q, b_d;
  logic [37:0]       s_q, s_d;
  logic [39:0]       dvd_q, dvd_d, rem_q, rem_d;
  logic [5:0]        dstep_q, dstep_d;
  logic [31:0]       time_q, time_d;
  logic [63:0]       mul_q;
  logic [31:0]       mul_a, mul_b;
  logic              ovalid_q, ovalid_d;
  logic [OUT_W-1:0]  odata_q, odata_d;

  // shared datapath pieces
  logic [37:0] nl2;
  logic [37:0] ln_sum;
  logic [40:0] rem_sh;
  logic        div_ge;
  logic [40:0] time_sum;
  logic [32:0] sq;
  logic [TOT_W:0] cum_nxt;
  logic [RATE_W:0] rate_add;
  logic [RATE_W-1:0] rate_new;

  assign nl2      = {6'd32, 32'd0} - {1'b0, e_q, frac_q};
  assign ln_sum   = s_q + {6'd0, mul_q[63:32]} + 38'd128;
  assign rem_sh   = {rem_q, dvd_q[39]};
  assign div_ge   = rem_sh >= {2'd0, tot_q};
  assign time_sum = {9'd0, time_q} + {1'b0, dvd_q};
  assign sq       = mul_q[63:31];
  assign cum_nxt  = cum_q + {{(TOT_W + 1 - RATE_W){1'b0}}, rt_rdata};
  assign rate_add = {1'b0, rt_rdata} + {{(RATE_W - 23){1'b0}}, beta_q};

  always_comb begin
    if (recov_q) begin
      rate_new = (rt_rdata > {{(RATE_W - 24){1'b0}}, beta_q})
               ? rt_rdata - {{(RATE_W - 24){1'b0}}, beta_q} : '0;
    end else begin
      rate_new = rate_add[RATE_W] ? RATE_MAX : rate_add[RATE_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    mul_q <= mul_a * mul_b;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= FSM_CLEAR;
      clr_q    <= '0;
      time_q   <= '0;
      ovalid_q <= 1'b0;
      rvld_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      clr_q    <= clr_d;
      time_q   <= time_d;
      ovalid_q <= ovalid_d;
      rvld_q   <= rvld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q   <= cmd_d;   node_q  <= node_d;  nb_q    <= nb_d;
    pf_q    <= pf_d;    tf_q    <= tf_d;    ff_q    <= ff_d;
    cnt_q   <= cnt_d;   ridx_q  <= ridx_d;
    sus_q   <= sus_d;   inf_q   <= inf_d;   rec_q   <= rec_d;
    tot_q   <= tot_d;   tgt_q   <= tgt_d;   cum_q   <= cum_d;
    found_q <= found_d; ev_q    <= ev_d;    infr_q  <= infr_d;
    v_q     <= v_d;     code_q  <= code_d;  sc_q    <= sc_d;
    deg_q   <= deg_d;   j_q     <= j_d;     k_q     <= k_d;
    seen_q  <= seen_d;  seed_q  <= seed_d;  recov_q <= recov_d;
    pass2_q <= pass2_d; want_q  <= want_d;  x_q     <= x_d;
    frac_q  <= frac_d;  e_q     <= e_d;     b_q     <= b_d;
    s_q     <= s_d;     dvd_q   <= dvd_d;   rem_q   <= rem_d;
    dstep_q <= dstep_d; odata_q <= odata_d;
  end

  // next state and datapath
  always_comb begin
    state_d = state_q;
    clr_d = clr_q;
    cmd_d = cmd_q; node_d = node_q; nb_d = nb_q;
    pf_d = pf_q; tf_d = tf_q; ff_d = ff_q;
    cnt_d = cnt_q; rvld_d = 1'b0; ridx_d = cnt_q[NODE_W-1:0];
    sus_d = sus_q; inf_d = inf_q; rec_d = rec_q;
    tot_d = tot_q; tgt_d = tgt_q; cum_d = cum_q; found_d = found_q;
    ev_d = ev_q; infr_d = infr_q; v_d = v_q; code_d = code_q; sc_d = sc_q;
    deg_d = deg_q; j_d = j_q; k_d = k_q; seen_d = seen_q;
    seed_d = seed_q; recov_d = recov_q; pass2_d = pass2_q; want_d = want_q;
    x_d = x_q; frac_d = frac_q; e_d = e_q; b_d = b_q; s_d = s_q;
    dvd_d = dvd_q; rem_d = rem_q; dstep_d = dstep_q; time_d = time_q;
    ovalid_d = ovalid_q && !m_axis_tready;
    odata_d = odata_q;

    case (state_q)
      FSM_CLEAR: begin
        clr_d = clr_q + 1'b1;
        if (&clr_q) state_d = FSM_IDLE;
      end
      FSM_IDLE: begin
        if (s_axis_tvalid) begin
          cmd_d  = s_axis_tdata[1:0];
          node_d = s_axis_tdata[11:2];
          nb_d   = s_axis_tdata[21:12];
          pf_d   = s_axis_tdata[53:22];
          tf_d   = s_axis_tdata[85:54];
          ff_d   = s_axis_tdata[117:86];
          cnt_d = '0; sus_d = '0; inf_d = '0; rec_d = '0; tot_d = '0;
          code_d = STATUS_FINISHED; ev_d = '0; infr_d = '0; sc_d = '0;
          k_d = '0; seen_d = '0; seed_d = 1'b0; recov_d = 1'b0; pass2_d = 1'b0;
          state_d = FSM_SCAN;
        end
      end
      FSM_SCAN, FSM_PICK: begin
        if (cnt_q < n_eff) begin
          rvld_d = 1'b1;
          cnt_d  = cnt_q + 1'b1;
        end
        if (rvld_q) begin
          if (state_q == FSM_SCAN) begin
            tot_d = tot_q + {{NODE_W{1'b0}}, rt_rdata};
            case (st_rdata)
              NS_SUS:  sus_d = sus_q + 1'b1;
              NS_INF:  inf_d = inf_q + 1'b1;
              default: rec_d = rec_q + 1'b1;
            endcase
          end else begin
            cum_d = cum_nxt;
            if (!found_q && cum_nxt > tgt_q) begin
              found_d = 1'b1;
              ev_d    = ridx_q;
            end
          end
        end
        if (cnt_q == n_eff && !rvld_q) begin
          state_d = (state_q == FSM_SCAN) ? FSM_DECIDE : FSM_EV_RD;
        end
      end
      FSM_DECIDE: begin
        state_d = FSM_FINISH;
        case (cmd_e'(cmd_q))
          CMD_ADD: begin
            ev_d = node_q;
            code_d = STATUS_FULL;
            if ({1'b0, node_q} < n_eff && {1'b0, nb_q} < n_eff) state_d = FSM_ADD_RD;
          end
          CMD_SEED: begin
            ev_d = node_q;
            code_d = STATUS_FULL;
            if ({1'b0, node_q} < n_eff) state_d = FSM_SEED_RD;
          end
          CMD_SIM: begin
            if (time_q < tmax_q && inf_q != '0 && tot_q != '0) state_d = FSM_TGT_LO;
          end
          default: ;
        endcase
      end
      FSM_ADD_RD: begin
        if (dg_rdata < DEG_W'(MAX_DEGREE)) code_d = STATUS_STORED;
        state_d = FSM_FINISH;
      end
      FSM_SEED_RD: begin
        if (st_rdata == NS_SUS) begin
          seed_d  = 1'b1;
          state_d = FSM_INFECT;
        end else begin
          state_d = FSM_FINISH;
        end
      end
      FSM_TGT_LO: state_d = FSM_TGT_HI;
      FSM_TGT_HI: begin
        tgt_d = {{(TOT_W + 1 - 32){1'b0}}, mul_q[63:32]};
        state_d = FSM_TGT_SUM;
      end
      FSM_TGT_SUM: begin
        tgt_d = tgt_q + mul_q[TOT_W:0];
        cnt_d = '0; cum_d = '0; found_d = 1'b0;
        ev_d = NODE_W'(n_eff - 1'b1);
        state_d = FSM_PICK;
      end
      FSM_EV_RD: state_d = FSM_EV_ST;
      FSM_EV_ST: begin
        case (st_rdata)
          NS_SUS: state_d = FSM_INFECT;
          NS_INF: state_d = FSM_RECOVER;
          default: begin
            ev_d = '0;
            state_d = FSM_FINISH;
          end
        endcase
      end
      FSM_INFECT: begin
        code_d = seed_q ? STATUS_SEEDED : STATUS_INFECTION;
        if (!seed_q) infr_d = ev_q;
        sus_d = sus_q - 1'b1;
        inf_d = inf_q + 1'b1;
        state_d = FSM_DEG;
      end
      FSM_RECOVER: begin
        code_d = STATUS_RECOVERY;
        recov_d = 1'b1;
        inf_d = inf_q - 1'b1;
        rec_d = rec_q + 1'b1;
        state_d = FSM_DEG;
      end
      FSM_DEG: begin
        deg_d = dg_rdata;
        j_d = '0;
        state_d = FSM_NB_ADDR;
      end
      FSM_NB_ADDR: begin
        if (j_q == deg_q) begin
          if (seed_q) state_d = FSM_FINISH;
          else if (recov_q || pass2_q) state_d = FSM_LOG;
          else state_d = FSM_WANT_MUL;
        end else begin
          state_d = FSM_NB_TAB;
        end
      end
      FSM_NB_TAB: begin
        v_d = tb_rdata;
        state_d = FSM_NB_ST;
      end
      FSM_NB_ST: begin
        j_d = j_q + 1'b1;
        state_d = FSM_NB_ADDR;
        if (pass2_q) begin
          if (st_rdata == NS_INF) begin
            if (seen_q == {1'b0, want_q}) begin
              infr_d = v_q;
              state_d = FSM_LOG;
            end else begin
              seen_d = seen_q + 1'b1;
            end
          end
        end else if (st_rdata == NS_SUS) begin
          j_d = j_q;
          if (!recov_q) sc_d = sc_q + 1'b1;
          state_d = FSM_NB_RATE;
        end else if (st_rdata == NS_INF && !recov_q) begin
          k_d = k_q + 1'b1;
        end
      end
      FSM_NB_RATE: begin
        j_d = j_q + 1'b1;
        state_d = FSM_NB_ADDR;
      end
      FSM_WANT_MUL: state_d = FSM_WANT;
      FSM_WANT: begin
        want_d = mul_q[32 +: SLOT_W];
        if (k_q == '0) begin
          state_d = FSM_LOG;
        end else begin
          pass2_d = 1'b1;
          j_d = '0;
          state_d = FSM_NB_ADDR;
        end
      end
      FSM_LOG: begin
        x_d = tf_q;
        e_d = 5'd31;
        frac_d = '0;
        b_d = '0;
        if (tf_q == '0) begin
          dvd_d = '0; rem_d = '0; dstep_d = '0;
          state_d = FSM_DIV;
        end else begin
          state_d = FSM_NORM;
        end
      end
      FSM_NORM: begin
        // msb search, one bit a cycle
        if (x_q[31]) begin
          state_d = FSM_SQ_MUL;
        end else begin
          x_d = {x_q[30:0], 1'b0};
          e_d = e_q - 1'b1;
        end
      end
      FSM_SQ_MUL: state_d = FSM_SQ;
      FSM_SQ: begin
        if (sq[32]) begin
          x_d = sq[32:1];
          frac_d = {frac_q[30:0], 1'b1};
        end else begin
          x_d = sq[31:0];
          frac_d = {frac_q[30:0], 1'b0};
        end
        b_d = b_q + 1'b1;
        state_d = (&b_q) ? FSM_LN_HI : FSM_SQ_MUL;
      end
      FSM_LN_HI: state_d = FSM_LN_LO;
      FSM_LN_LO: begin
        s_d = mul_q[37:0];
        state_d = FSM_LN_SUM;
      end
      FSM_LN_SUM: begin
        // round half up to Q6.24, then scale by 256 for the Q16.16 quotient
        dvd_d = {2'd0, ln_sum[37:8], 8'd0};
        rem_d = '0;
        dstep_d = '0;
        state_d = FSM_DIV;
      end
      FSM_DIV: begin
        rem_d = div_ge ? 40'(rem_sh - {2'd0, tot_q}) : rem_sh[39:0];
        dvd_d = {dvd_q[38:0], div_ge};
        dstep_d = dstep_q + 1'b1;
        if (dstep_q == 6'd39) state_d = FSM_TIME;
      end
      FSM_TIME: begin
        time_d = (time_sum[40:32] != '0) ? '1 : time_sum[31:0];
        state_d = FSM_FINISH;
      end
      FSM_FINISH: begin
        if (!ovalid_q || m_axis_tready) begin
          ovalid_d = 1'b1;
          odata_d = '0;
          odata_d[O_CODE +: 3]      = code_q;
          odata_d[O_EV +: NODE_W]   = (code_q == STATUS_FINISHED) ? '0 : ev_q;
          odata_d[O_TIME +: 32]     = time_q;
          odata_d[O_INFR +: NODE_W] = (code_q == STATUS_INFECTION) ? infr_q : '0;
          odata_d[O_SC +: DEG_W]    = (code_q == STATUS_SEEDED ||
                                       code_q == STATUS_INFECTION) ? sc_q : '0;
          odata_d[O_INF +: CNT_W]   = inf_q;
          odata_d[O_SUS +: CNT_W]   = sus_q;
          odata_d[O_REC +: CNT_W]   = rec_q;
          state_d = FSM_IDLE;
        end
      end
      default: state_d = FSM_IDLE;
    endcase
  end

  // memory ports, multiplier operands and handshake
  always_comb begin
    st_we = 1'b0; st_waddr = ev_q; st_wdata = NS_SUS; st_raddr = cnt_q[NODE_W-1:0];
    rt_we = 1'b0; rt_waddr = ev_q; rt_wdata = '0;     rt_raddr = cnt_q[NODE_W-1:0];
    dg_we = 1'b0; dg_waddr = node_q; dg_wdata = dg_rdata + 1'b1; dg_raddr = ev_q;
    tb_we = 1'b0; tb_waddr = {node_q, dg_rdata[SLOT_W-1:0]}; tb_wdata = nb_q;
    tb_raddr = {ev_q, j_q[SLOT_W-1:0]};
    mul_a = '0;
    mul_b = '0;

    case (state_q)
      FSM_CLEAR: begin
        st_we = 1'b1; st_waddr = clr_q;
        rt_we = 1'b1; rt_waddr = clr_q;
        dg_we = 1'b1; dg_waddr = clr_q; dg_wdata = '0;
      end
      FSM_DECIDE: begin
        dg_raddr = node_q;
        st_raddr = node_q;
      end
      FSM_ADD_RD: begin
        if (dg_rdata < DEG_W'(MAX_DEGREE)) begin
          dg_we = 1'b1;
          tb_we = 1'b1;
        end
      end
      FSM_TGT_LO: begin
        mul_a = pf_q;
        mul_b = tot_q[31:0];
      end
      FSM_TGT_HI: begin
        mul_a = pf_q;
        mul_b = {{(64 - TOT_W){1'b0}}, tot_q[TOT_W-1:32]};
      end
      FSM_EV_RD: st_raddr = ev_q;
      FSM_INFECT: begin
        st_we = 1'b1; st_wdata = NS_INF;
        rt_we = 1'b1; rt_wdata = {{(RATE_W - 24){1'b0}}, gamma_q};
      end
      FSM_RECOVER: begin
        st_we = 1'b1; st_wdata = NS_REC;
        rt_we = 1'b1; rt_wdata = '0;
      end
      FSM_NB_TAB: st_raddr = tb_rdata;
      FSM_NB_ST:  rt_raddr = v_q;
      FSM_NB_RATE: begin
        rt_we = 1'b1; rt_waddr = v_q; rt_wdata = rate_new;
      end
      FSM_WANT_MUL: begin
        mul_a = ff_q;
        mul_b = {{(32 - DEG_W){1'b0}}, k_q};
      end
      FSM_SQ_MUL: begin
        mul_a = x_q;
        mul_b = x_q;
      end
      FSM_LN_HI: begin
        mul_a = {26'd0, nl2[37:32]};
        mul_b = LN2_Q32;
      end
      FSM_LN_LO: begin
        mul_a = nl2[31:0];
        mul_b = LN2_Q32;
      end
      default: ;
    endcase
  end

  assign s_axis_tready = (state_q == FSM_IDLE);
  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = odata_q;

endmodule

@@ src/nsgs_checker.sv @@
`timescale 1ns / 1ps

module nsgs_checker
  import nsgs_pkg::*;
(
  input logic             clk_i,
  input logic             rst_ni,
  input logic [IN_W-1:0]  s_axis_tdata,
  input logic             s_axis_tvalid,
  input logic             s_axis_tready,
  input logic [OUT_W-1:0] m_axis_tdata,
  input logic             m_axis_tvalid,
  input logic             m_axis_tready
);

  logic [CNT_W+1:0] pop_sum;
  assign pop_sum = {2'b0, m_axis_tdata[O_INF +: CNT_W]}
                 + {2'b0, m_axis_tdata[O_SUS +: CNT_W]}
                 + {2'b0, m_axis_tdata[O_REC +: CNT_W]};

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken twice in a row");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[O_CODE +: 3] <= STATUS_FINISHED)
    else $error("status code out of range");

  a_population: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> pop_sum <= (CNT_W + 2)'(MAX_NODES))
    else $error("tallies exceed node count");

  a_infector_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[O_CODE +: 3] != STATUS_INFECTION
      |-> m_axis_tdata[O_INFR +: NODE_W] == '0)
    else $error("infector set outside infection");

endmodule

bind network_sir_gillespie_step_core nsgs_checker u_nsgs_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tdata  (s_axis_tdata),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready)
);
